@@ rtl/core/mcss_pkg.sv @@
// ----------------------------------------------------------------------------
// mcss_pkg
// Shared types, codes and the legal-transition table of the run-state
// supervisor.
// ----------------------------------------------------------------------------
package mcss_pkg;

    localparam int StateW   = 5;
    localparam int CmdW     = 3;
    localparam int WordW    = 32;
    localparam int HoldW    = 16;
    localparam int CfgIdxW  = 2;
    localparam int InDataW  = 72;
    localparam int OutDataW = 168;

    // Run-state codes (dense numbering, also the output code)
    localparam logic [StateW-1:0] StIdle          = 5'd0;
    localparam logic [StateW-1:0] StIdleAlignment = 5'd1;
    localparam logic [StateW-1:0] StIdleStart     = 5'd3;
    localparam logic [StateW-1:0] StAnyStop       = 5'd7;
    localparam logic [StateW-1:0] StStopIdle      = 5'd9;
    localparam logic [StateW-1:0] StFaultNow      = 5'd10;
    localparam logic [StateW-1:0] StFaultOver     = 5'd11;
    localparam logic [StateW-1:0] StAutotuneFirst = 5'd21;

    // Command codes
    localparam logic [CmdW-1:0] CmdStateReq = 3'd0;
    localparam logic [CmdW-1:0] CmdFault    = 3'd1;
    localparam logic [CmdW-1:0] CmdError    = 3'd2;
    localparam logic [CmdW-1:0] CmdTick     = 3'd3;
    localparam logic [CmdW-1:0] CmdWarning  = 3'd4;
    localparam logic [CmdW-1:0] CmdFaultAck = 3'd5;

    // Register indexes
    localparam logic [CfgIdxW-1:0] RegHoldTicks = 2'd0;
    localparam logic [CfgIdxW-1:0] RegSwfMask   = 2'd1;
    localparam logic [CfgIdxW-1:0] RegAtEnable  = 2'd2;

    localparam logic [HoldW-1:0] HoldReset = 16'd2000;
    localparam logic [WordW-1:0] SwfReset  = 32'd128;

    typedef struct packed {
        logic [HoldW-1:0] hold_ticks;
        logic [WordW-1:0] swf_mask;
        logic             at_en;
    } t_cfg;

    typedef struct packed {
        logic [CmdW-1:0]   command;
        logic [StateW-1:0] requested_state;
        logic [WordW-1:0]  set_bits;
        logic [WordW-1:0]  clear_bits;
    } t_item;

    typedef struct packed {
        logic [StateW-1:0] run_state;
        logic [WordW-1:0]  fault_word;
        logic [WordW-1:0]  fault_record;
        logic [WordW-1:0]  error_word;
        logic [WordW-1:0]  error_record;
        logic [WordW-1:0]  warning_word;
        logic [HoldW-1:0]  hold_counter;
    } t_words;

    // Legal successors of a state, one bit per target code
    function automatic logic [WordW-1:0] legal_next(input logic [StateW-1:0] st);
        logic [WordW-1:0] m;
        m = '0;
        case (st)
            5'd0:  m = (32'd1 << 3) | (32'd1 << 1) | (32'd1 << 12) | (32'd1 << 21);
            5'd1:  m = (32'd1 << 7) | (32'd1 << 13) | (32'd1 << 14);
            5'd2:  m = (32'd1 << 7);
            5'd3:  m = (32'd1 << 7) | (32'd1 << 16) | (32'd1 << 4) | (32'd1 << 17)
                       | (32'd1 << 1);
            5'd4:  m = (32'd1 << 19) | (32'd1 << 7) | (32'd1 << 5);
            5'd5:  m = (32'd1 << 6) | (32'd1 << 7);
            5'd6:  m = (32'd1 << 7);
            5'd7:  m = (32'd1 << 8);
            5'd8:  m = (32'd1 << 9);
            5'd9:  m = (32'd1 << 0) | (32'd1 << 12);
            5'd12: m = (32'd1 << 0);
            5'd13: m = (32'd1 << 14) | (32'd1 << 7);
            5'd14: m = (32'd1 << 15) | (32'd1 << 7);
            5'd15: m = (32'd1 << 2) | (32'd1 << 7);
            5'd16: m = (32'd1 << 17) | (32'd1 << 7);
            5'd17: m = (32'd1 << 18) | (32'd1 << 7) | (32'd1 << 20);
            5'd18: m = (32'd1 << 4) | (32'd1 << 7);
            5'd19: m = (32'd1 << 4) | (32'd1 << 7) | (32'd1 << 5);
            5'd20: m = (32'd1 << 18) | (32'd1 << 7);
            5'd21: m = (32'd1 << 22);
            5'd22: m = (32'd1 << 23);
            5'd23: m = (32'd1 << 24);
            5'd24: m = (32'd1 << 0);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/mcss_step.sv @@
// ----------------------------------------------------------------------------
// mcss_step
// Next-state logic for one command: transition check, fault latch, error
// hold and warning update.
// ----------------------------------------------------------------------------
module mcss_step (
    input  mcss_pkg::t_cfg   i_cfg,
    input  mcss_pkg::t_words i_cur,
    input  mcss_pkg::t_item  i_item,
    output mcss_pkg::t_words o_nxt,
    output logic             o_accepted
);

    logic [mcss_pkg::WordW-1:0]  allowed;
    logic                        req_ok;
    logic                        req_exempt;
    logic                        do_fault;
    logic [mcss_pkg::WordW-1:0]  f_set;
    logic [mcss_pkg::WordW-1:0]  f_clr;
    logic [mcss_pkg::WordW-1:0]  f_word;
    logic [mcss_pkg::WordW-1:0]  e_word;
    logic [mcss_pkg::HoldW-1:0]  cnt_inc;

    always_comb begin
        allowed = mcss_pkg::legal_next(i_cur.run_state);
        if (i_cur.run_state >= mcss_pkg::StAutotuneFirst && !i_cfg.at_en) begin
            allowed = '0;
        end
        // codes 25..31 have no bit in any mask
        req_ok     = allowed[i_item.requested_state];
        req_exempt = (i_item.requested_state == mcss_pkg::StIdleStart)
                  || (i_item.requested_state == mcss_pkg::StIdleAlignment)
                  || (i_item.requested_state == mcss_pkg::StAnyStop);

        do_fault = (i_item.command == mcss_pkg::CmdFault)
                || (i_item.command == mcss_pkg::CmdStateReq && !req_ok && !req_exempt);
        f_set = (i_item.command == mcss_pkg::CmdFault) ? i_item.set_bits : i_cfg.swf_mask;
        f_clr = (i_item.command == mcss_pkg::CmdFault) ? i_item.clear_bits : '0;
        f_word = (i_cur.fault_word | f_set) & ~f_clr;

        e_word  = (i_cur.error_word | i_item.set_bits) & ~i_item.clear_bits;
        cnt_inc = i_cur.hold_counter + 1'b1;

        o_nxt      = i_cur;
        o_accepted = 1'b0;

        if (do_fault) begin
            o_nxt.fault_word   = f_word;
            o_nxt.fault_record = i_cur.fault_record | f_set;
            if (i_cur.run_state == mcss_pkg::StFaultNow) begin
                if (f_word == '0) begin
                    o_nxt.run_state = mcss_pkg::StFaultOver;
                end
            end else if (f_word != '0) begin
                o_nxt.run_state = mcss_pkg::StFaultNow;
            end
        end

        case (i_item.command)
            mcss_pkg::CmdStateReq: begin
                if (req_ok) begin
                    o_nxt.run_state = i_item.requested_state;
                    o_accepted      = 1'b1;
                end
            end
            mcss_pkg::CmdError: begin
                o_nxt.error_word = e_word;
                if (e_word != '0) begin
                    o_nxt.error_record = e_word;
                end
            end
            mcss_pkg::CmdTick: begin
                if (i_cur.error_record != '0 && i_cur.error_word == '0) begin
                    if (cnt_inc >= i_cfg.hold_ticks) begin
                        o_nxt.hold_counter = '0;
                        o_nxt.error_record = '0;
                    end else begin
                        o_nxt.hold_counter = cnt_inc;
                    end
                end
            end
            mcss_pkg::CmdWarning: begin
                o_nxt.warning_word = (i_cur.warning_word | i_item.set_bits)
                                   & ~i_item.clear_bits;
            end
            mcss_pkg::CmdFaultAck: begin
                if (i_cur.run_state == mcss_pkg::StFaultOver) begin
                    o_nxt.run_state    = mcss_pkg::StStopIdle;
                    o_nxt.fault_record = '0;
                    o_accepted         = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/core/motor_control_state_supervisor.sv @@
// ----------------------------------------------------------------------------
// motor_control_state_supervisor
// Run-state supervisor for a motor drive with critical-fault latch, error
// hold timer and warning word.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_axis channel, one per transfer. Each command
//   produces exactly one result transfer on m_axis carrying the accepted
//   flag, the run state and the fault, error and warning words after it.
//   The configuration port writes hold ticks (index 0), software fault
//   mask (index 1) and autotune enable (index 2); write only while idle.
// Timing:
//   A transfer goes into an input register; when the result register is free
//   or being read, one pass of the transition/mask logic moves it into the
//   result register. One command per cycle sustained while m_axis_tready
//   stays high; the state registers update as each command leaves the input
//   register.
// Reset:
//   Synchronous, active low. State goes to IDLE, all words and the hold
//   counter clear, registers take their defaults (2000, 0x80, 1).
// Stall:
//   If m_axis_tready is low the result holds, one more command waits in
//   the input register, and s_axis_tready then drops.
// ----------------------------------------------------------------------------
module motor_control_state_supervisor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // command[2:0], requested_state[7:3], set_bits[39:8], clear_bits[71:40]
    input  logic [mcss_pkg::InDataW-1:0]     s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // accepted[0], current_state[5:1], faults_present[37:6],
    // faults_history[69:38], errors_present[101:70], errors_held[133:102],
    // warnings_present[165:134], zero pad[167:166]
    output logic [mcss_pkg::OutDataW-1:0]    m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [mcss_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [mcss_pkg::WordW-1:0]       i_cfg_wdata
);

    mcss_pkg::t_cfg   r_cfg;
    mcss_pkg::t_words r_words;
    mcss_pkg::t_words n_words;
    mcss_pkg::t_item  r_item;
    logic             r_in_valid;
    logic             r_out_valid;
    logic [mcss_pkg::OutDataW-1:0] r_out_data;
    logic             n_accepted;
    logic             fire;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    mcss_step u_step (
        .i_cfg      (r_cfg),
        .i_cur      (r_words),
        .i_item     (r_item),
        .o_nxt      (n_words),
        .o_accepted (n_accepted)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks <= mcss_pkg::HoldReset;
            r_cfg.swf_mask   <= mcss_pkg::SwfReset;
            r_cfg.at_en      <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mcss_pkg::RegHoldTicks: r_cfg.hold_ticks <= i_cfg_wdata[mcss_pkg::HoldW-1:0];
                mcss_pkg::RegSwfMask:   r_cfg.swf_mask   <= i_cfg_wdata;
                mcss_pkg::RegAtEnable:  r_cfg.at_en      <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_words     <= '{run_state: mcss_pkg::StIdle, default: '0};
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_words     <= n_words;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.command         <= s_axis_tdata[2:0];
            r_item.requested_state <= s_axis_tdata[7:3];
            r_item.set_bits        <= s_axis_tdata[39:8];
            r_item.clear_bits      <= s_axis_tdata[71:40];
        end
        if (fire) begin
            r_out_data <= {2'b00, n_words.warning_word, n_words.error_record,
                           n_words.error_word, n_words.fault_record,
                           n_words.fault_word, n_words.run_state, n_accepted};
        end
    end

endmodule

@@ bench/motor_control_state_supervisor_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_control_state_supervisor_tb
// Self-checking bench for the run-state supervisor. Commands go in on the
// slave stream, and a local tracker of the run state and of the fault, error
// and warning words predicts each result. Every result transfer is checked
// field by field. A short directed sequence is followed by random phases
// under different register settings, with random idling on both streams.
// ----------------------------------------------------------------------------
module motor_control_state_supervisor_tb;

    // Commands outside the defined set, still legal on the wire
    localparam logic [mcss_pkg::CmdW-1:0] CmdSpareLo = 3'd6;
    localparam logic [mcss_pkg::CmdW-1:0] CmdSpareHi = 3'd7;
    localparam int NumStates = 25;

    typedef struct packed {
        logic                        acc;
        logic [mcss_pkg::StateW-1:0] state;
        logic [mcss_pkg::WordW-1:0]  faults;
        logic [mcss_pkg::WordW-1:0]  fault_hist;
        logic [mcss_pkg::WordW-1:0]  errors;
        logic [mcss_pkg::WordW-1:0]  errors_held;
        logic [mcss_pkg::WordW-1:0]  warnings;
    } t_status;

    class run_state_tracker;
        logic [mcss_pkg::HoldW-1:0]  hold_ticks;
        logic [mcss_pkg::WordW-1:0]  swf_mask;
        logic                        at_en;
        logic [mcss_pkg::StateW-1:0] run_state;
        logic [mcss_pkg::WordW-1:0]  fault_word;
        logic [mcss_pkg::WordW-1:0]  fault_record;
        logic [mcss_pkg::WordW-1:0]  error_word;
        logic [mcss_pkg::WordW-1:0]  error_record;
        logic [mcss_pkg::WordW-1:0]  warning_word;
        logic [mcss_pkg::HoldW-1:0]  hold_count;
        logic [mcss_pkg::WordW-1:0]  successor_map [NumStates];
        t_status                     pending [$];
        int                          mismatches;
        int                          checked;
        int                          commands;
        int                          requests_taken;
        int                          fault_entries;
        int                          acks_taken;
        int                          releases;

        function new();
            // one bit per legal target state
            successor_map = '{32'h0020_100A, 32'h0000_6080, 32'h0000_0080,
                              32'h0003_0092, 32'h0008_00A0, 32'h0000_00C0,
                              32'h0000_0080, 32'h0000_0100, 32'h0000_0200,
                              32'h0000_1001, 32'h0000_0000, 32'h0000_0000,
                              32'h0000_0001, 32'h0000_4080, 32'h0000_8080,
                              32'h0000_0084, 32'h0002_0080, 32'h0014_0080,
                              32'h0000_0090, 32'h0000_00B0, 32'h0004_0080,
                              32'h0040_0000, 32'h0080_0000, 32'h0100_0000,
                              32'h0000_0001};
            hold_ticks   = mcss_pkg::HoldReset;
            swf_mask     = mcss_pkg::SwfReset;
            at_en        = 1'b1;
            run_state    = mcss_pkg::StIdle;
            fault_word   = '0;
            fault_record = '0;
            error_word   = '0;
            error_record = '0;
            warning_word = '0;
            hold_count   = '0;
        endfunction

        function void set_register(logic [mcss_pkg::CfgIdxW-1:0] idx,
                                   logic [mcss_pkg::WordW-1:0] val);
            case (idx)
                mcss_pkg::RegHoldTicks: hold_ticks = val[mcss_pkg::HoldW-1:0];
                mcss_pkg::RegSwfMask:   swf_mask   = val;
                mcss_pkg::RegAtEnable:  at_en      = val[0];
                default: ;
            endcase
        endfunction

        function logic [mcss_pkg::WordW-1:0] allowed_targets();
            if (run_state >= mcss_pkg::StAutotuneFirst && !at_en)
                return '0;
            if (run_state < NumStates)
                return successor_map[run_state];
            return '0;
        endfunction

        function void apply_faults(logic [mcss_pkg::WordW-1:0] set_m,
                                   logic [mcss_pkg::WordW-1:0] clr_m);
            fault_word   = (fault_word | set_m) & ~clr_m;
            fault_record = fault_record | set_m;
            if (run_state == mcss_pkg::StFaultNow) begin
                if (fault_word == '0)
                    run_state = mcss_pkg::StFaultOver;
            end else if (fault_word != '0) begin
                run_state = mcss_pkg::StFaultNow;
                fault_entries++;
            end
        endfunction

        function logic request_state(logic [mcss_pkg::StateW-1:0] req);
            logic [mcss_pkg::WordW-1:0] allowed;
            allowed = allowed_targets();
            if (allowed[req]) begin
                run_state = req;
                requests_taken++;
                return 1'b1;
            end
            // refused start, align and stop requests are harmless
            if (!(req == mcss_pkg::StIdleStart || req == mcss_pkg::StIdleAlignment
                  || req == mcss_pkg::StAnyStop))
                apply_faults(swf_mask, '0);
            return 1'b0;
        endfunction

        function void note_command(mcss_pkg::t_item it);
            t_status s;
            logic    took;
            took = 1'b0;
            case (it.command)
                mcss_pkg::CmdStateReq: took = request_state(it.requested_state);
                mcss_pkg::CmdFault:    apply_faults(it.set_bits, it.clear_bits);
                mcss_pkg::CmdError: begin
                    error_word = (error_word | it.set_bits) & ~it.clear_bits;
                    if (error_word != '0)
                        error_record = error_word;
                end
                mcss_pkg::CmdTick: begin
                    if (error_record != '0 && error_word == '0) begin
                        hold_count = hold_count + 1'b1;
                        if (hold_count >= hold_ticks) begin
                            hold_count   = '0;
                            error_record = '0;
                            releases++;
                        end
                    end
                end
                mcss_pkg::CmdWarning:
                    warning_word = (warning_word | it.set_bits) & ~it.clear_bits;
                mcss_pkg::CmdFaultAck: begin
                    if (run_state == mcss_pkg::StFaultOver) begin
                        run_state    = mcss_pkg::StStopIdle;
                        fault_record = '0;
                        took         = 1'b1;
                        acks_taken++;
                    end
                end
                default: ;
            endcase
            s.acc         = took;
            s.state       = run_state;
            s.faults      = fault_word;
            s.fault_hist  = fault_record;
            s.errors      = error_word;
            s.errors_held = error_record;
            s.warnings    = warning_word;
            pending.push_back(s);
            commands++;
        endfunction

        function void compare_field(string name, logic [mcss_pkg::WordW-1:0] want,
                                    logic [mcss_pkg::WordW-1:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: %s expected %h, got %h", checked, name, want, got);
            end
        endfunction

        function void check_status(logic [mcss_pkg::OutDataW-1:0] data);
            t_status want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing outstanding: %h", checked, data);
                checked++;
                return;
            end
            want = pending.pop_front();
            compare_field("accepted", 32'(want.acc), 32'(data[0]));
            compare_field("current_state", 32'(want.state), 32'(data[5:1]));
            compare_field("faults_present", want.faults, data[37:6]);
            compare_field("faults_history", want.fault_hist, data[69:38]);
            compare_field("errors_present", want.errors, data[101:70]);
            compare_field("errors_held", want.errors_held, data[133:102]);
            compare_field("warnings_present", want.warnings, data[165:134]);
            compare_field("pad", '0, 32'(data[167:166]));
            checked++;
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [mcss_pkg::InDataW-1:0]   s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [mcss_pkg::OutDataW-1:0]  m_axis_tdata;
    logic                           i_cfg_we;
    logic [mcss_pkg::CfgIdxW-1:0]   i_cfg_index;
    logic [mcss_pkg::WordW-1:0]     i_cfg_wdata;

    run_state_tracker tracker;
    int               idle_pct = 24;
    int               settings_used = 1;

    motor_control_state_supervisor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // result side: random back-pressure, check every transfer
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_status(m_axis_tdata);
    end

    task automatic drive_item(input mcss_pkg::t_item it);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.clear_bits, it.set_bits, it.requested_state, it.command};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.note_command(it);
    endtask

    task automatic send_command(input logic [mcss_pkg::CmdW-1:0] cmd,
                                input logic [mcss_pkg::StateW-1:0] req,
                                input logic [mcss_pkg::WordW-1:0] set_m,
                                input logic [mcss_pkg::WordW-1:0] clr_m);
        mcss_pkg::t_item it;
        it.command         = cmd;
        it.requested_state = req;
        it.set_bits        = set_m;
        it.clear_bits      = clr_m;
        drive_item(it);
    endtask

    // let every outstanding result come back, then settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [mcss_pkg::HoldW-1:0] hold,
                             input logic [mcss_pkg::WordW-1:0] mask,
                             input logic at);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mcss_pkg::RegHoldTicks;
        i_cfg_wdata <= 32'(hold);
        @(posedge i_clk);
        tracker.set_register(mcss_pkg::RegHoldTicks, 32'(hold));
        i_cfg_index <= mcss_pkg::RegSwfMask;
        i_cfg_wdata <= mask;
        @(posedge i_clk);
        tracker.set_register(mcss_pkg::RegSwfMask, mask);
        i_cfg_index <= mcss_pkg::RegAtEnable;
        i_cfg_wdata <= 32'(at);
        @(posedge i_clk);
        tracker.set_register(mcss_pkg::RegAtEnable, 32'(at));
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // legal walks through the state table, plus fault, error, tick, warning and
    // acknowledge traffic; the rest is illegal requests and spare commands
    function automatic mcss_pkg::t_item random_command();
        mcss_pkg::t_item            it;
        logic [mcss_pkg::WordW-1:0] allowed;
        int                         targets [$];
        int                         r;
        it.command         = mcss_pkg::CmdStateReq;
        it.requested_state = 5'($urandom_range(31));
        it.set_bits        = $urandom;
        it.clear_bits      = $urandom;
        r = $urandom_range(99);
        if (tracker.run_state == mcss_pkg::StFaultNow && r < 60) begin
            it.command    = mcss_pkg::CmdFault;
            it.set_bits   = ($urandom_range(3) == 0) ? $urandom : '0;
            it.clear_bits = '1;
            return it;
        end
        if (tracker.run_state == mcss_pkg::StFaultOver && r < 50) begin
            it.command = mcss_pkg::CmdFaultAck;
            return it;
        end
        r = $urandom_range(99);
        if (r < 45) begin
            allowed = tracker.allowed_targets();
            for (int i = 0; i < NumStates; i++)
                if (allowed[i])
                    targets.push_back(i);
            if (targets.size() != 0 && $urandom_range(99) < 80)
                it.requested_state = 5'(targets[$urandom_range(targets.size() - 1)]);
        end else if (r < 51) begin
            it.command    = mcss_pkg::CmdFault;
            it.set_bits   = ($urandom_range(1) == 0) ? (32'd1 << $urandom_range(31)) : $urandom;
        end else if (r < 61) begin
            it.command    = mcss_pkg::CmdError;
            it.set_bits   = $urandom & $urandom;
            if ($urandom_range(1) == 0)
                it.clear_bits = '1;
        end else if (r < 79) begin
            it.command = mcss_pkg::CmdTick;
        end else if (r < 87) begin
            it.command = mcss_pkg::CmdWarning;
        end else if (r < 96) begin
            it.command = mcss_pkg::CmdFaultAck;
        end else begin
            it.command = ($urandom_range(1) == 0) ? CmdSpareLo : CmdSpareHi;
        end
        return it;
    endfunction

    task automatic run_phase(input logic [mcss_pkg::HoldW-1:0] hold,
                             input logic [mcss_pkg::WordW-1:0] mask,
                             input logic at, input int count, input int pct);
        idle_pct = pct;
        configure(hold, mask, at);
        repeat (count) drive_item(random_command());
        drain();
    endtask

    initial begin
        tracker = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= mcss_pkg::RegHoldTicks;
        i_cfg_wdata   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: word extremes, each command, the refusal rules
        send_command(mcss_pkg::CmdWarning, 5'd0, '1, '0);
        send_command(mcss_pkg::CmdWarning, 5'd31, '0, '1);
        send_command(mcss_pkg::CmdError, 5'd0, 32'h8000_0001, '0);
        send_command(mcss_pkg::CmdTick, 5'd0, '0, '0);
        send_command(mcss_pkg::CmdError, 5'd0, '0, '1);
        send_command(mcss_pkg::CmdTick, 5'd0, '0, '0);
        send_command(mcss_pkg::CmdStateReq, mcss_pkg::StIdleStart, '0, '0);
        send_command(mcss_pkg::CmdStateReq, 5'd4, '0, '0);
        send_command(mcss_pkg::CmdStateReq, 5'd31, '0, '0);      // out of range target
        send_command(mcss_pkg::CmdFaultAck, 5'd0, '0, '0);       // ack while fault present
        send_command(mcss_pkg::CmdStateReq, mcss_pkg::StAnyStop, '0, '0);  // refused, no fault
        send_command(mcss_pkg::CmdFault, 5'd0, '0, '1);
        send_command(mcss_pkg::CmdFaultAck, 5'd0, '0, '0);
        send_command(mcss_pkg::CmdStateReq, mcss_pkg::StIdle, '0, '0);
        send_command(mcss_pkg::CmdStateReq, mcss_pkg::StAutotuneFirst, '0, '0);
        send_command(mcss_pkg::CmdStateReq, 5'd22, '0, '0);
        send_command(CmdSpareLo, 5'd0, '0, '0);
        send_command(CmdSpareHi, 5'd31, '1, '1);
        send_command(mcss_pkg::CmdFault, 5'd0, '1, '0);
        send_command(mcss_pkg::CmdFault, 5'd0, 32'h0000_0001, '1);  // set then cleared
        send_command(mcss_pkg::CmdFaultAck, 5'd0, '0, '0);
        send_command(mcss_pkg::CmdStateReq, mcss_pkg::StIdleAlignment, '0, '0);
        send_command(mcss_pkg::CmdStateReq, 5'd24, '0, '0);
        send_command(mcss_pkg::CmdFault, 5'd0, '0, '1);
        send_command(mcss_pkg::CmdFaultAck, 5'd0, '0, '0);
        drain();

        run_phase(16'd1, '1, 1'b1, 180, 24);
        run_phase(16'hFFFF, '0, 1'b0, 150, 24);
        run_phase(16'd3, $urandom, 1'b1, 200, 0);
        run_phase(16'd7, 32'h8000_0000, 1'b0, 200, 24);
        run_phase(16'd2, 32'd128, 1'b1, 200, 24);

        $display("Ran %0d commands over %0d register settings: %0d requests taken,",
                 tracker.commands, settings_used, tracker.requests_taken);
        $display("%0d fault entries, %0d acknowledges taken, %0d held-error releases;",
                 tracker.fault_entries, tracker.acks_taken, tracker.releases);
        $display("%0d results checked, %0d mismatches.", tracker.checked, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("Timed out with %0d results outstanding", tracker.pending.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
